[sv/irclt_pkg.sv]
// Package for the IRC line tokenizer: parse phase type, field kind codes,
// character constants and the parser state and result word structs.
// No dependencies.
`timescale 1ns / 1ps

package irclt_pkg;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Field kind codes
    localparam logic [2:0] KIND_SEP    = 3'd0;
    localparam logic [2:0] KIND_PREFIX = 3'd1;
    localparam logic [2:0] KIND_CMD    = 3'd2;
    localparam logic [2:0] KIND_MIDDLE = 3'd3;
    localparam logic [2:0] KIND_TRAIL  = 3'd4;

    // Parser phase within one line
    typedef enum logic [2:0] {
        PH_LINE_START = 3'd0,
        PH_PREFIX     = 3'd1,
        PH_PRE_CMD    = 3'd2,
        PH_CMD        = 3'd3,
        PH_PRE_PARAM  = 3'd4,
        PH_MIDDLE     = 3'd5,
        PH_TRAILING   = 3'd6
    } phase_t;

    // Line parser state (the held CR lives outside)
    typedef struct packed {
        phase_t      phase;
        logic [3:0]  param_count;
        logic        overflow;
        logic        start_due;
    } parse_state_t;

    // One result word
    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] field_kind;
        logic [3:0] param_number;
        logic       field_start;
        logic       param_overflow;
        logic       line_end;
        logic       line_valid;
        logic       last_of_run;
    } out_item_t;

endpackage

[sv/irc_line_tokenizer.sv]
// IRC line tokenizer: the result words for each accepted byte are registered into a result queue.
// Throughput: one byte accepted per cycle while the 4-entry result queue has
// room for two words; a released CR adds one extra result word for that byte.
// Synchronous active-low reset returns the parser to line start, drops any
// held CR and empties the result queue.
// Depends on irclt_pkg.
`timescale 1ns / 1ps

module irc_line_tokenizer #(
    parameter int MAX_PARAMS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: in_byte[7:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // m_tdata: data_byte[7:0], param_number[11:8], field_start[12],
    //          param_overflow[13], line_end[14], line_valid[15]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // m_tuser: field_kind[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam logic [3:0] MAX_P = 4'(MAX_PARAMS);

    irclt_pkg::parse_state_t st_reg, st_next, st_mid;
    logic                    cr_held_reg, cr_held_next;

    irclt_pkg::out_item_t    q_reg [QDEPTH];
    logic [QAW-1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0]          cnt_reg, cnt_next;

    irclt_pkg::out_item_t    item0, item1;
    logic                    push0, push1;
    logic                    in_fire, out_fire;
    logic [QCW-1:0]          n_push;

    // Next parser state for one tagged byte
    function automatic irclt_pkg::parse_state_t next_state(
        input irclt_pkg::parse_state_t s, input logic [7:0] b);
        irclt_pkg::parse_state_t n;
        logic                    bp;
        n  = s;
        bp = 1'b0;
        unique case (s.phase)
            irclt_pkg::PH_PREFIX: begin
                if (b == irclt_pkg::CH_SPACE) n.phase = irclt_pkg::PH_PRE_CMD;
                else                          n.start_due = 1'b0;
            end
            irclt_pkg::PH_PRE_CMD: begin
                if (b != irclt_pkg::CH_SPACE) n.phase = irclt_pkg::PH_CMD;
            end
            irclt_pkg::PH_CMD: begin
                if (b == irclt_pkg::CH_SPACE) n.phase = irclt_pkg::PH_PRE_PARAM;
            end
            irclt_pkg::PH_PRE_PARAM: begin
                if (b == irclt_pkg::CH_COLON) begin
                    bp          = 1'b1;
                    n.phase     = irclt_pkg::PH_TRAILING;
                    n.start_due = 1'b1;
                end else if (b != irclt_pkg::CH_SPACE) begin
                    bp      = 1'b1;
                    n.phase = irclt_pkg::PH_MIDDLE;
                end
            end
            irclt_pkg::PH_MIDDLE: begin
                if (b == irclt_pkg::CH_SPACE) n.phase = irclt_pkg::PH_PRE_PARAM;
            end
            irclt_pkg::PH_TRAILING: begin
                n.start_due = 1'b0;
            end
            default: begin
                if (b == irclt_pkg::CH_COLON) begin
                    n.phase     = irclt_pkg::PH_PREFIX;
                    n.start_due = 1'b1;
                end else if (b == irclt_pkg::CH_SPACE) begin
                    n.phase = irclt_pkg::PH_PRE_CMD;
                end else begin
                    n.phase = irclt_pkg::PH_CMD;
                end
            end
        endcase
        // Parameter count saturates, overflow is sticky
        if (bp) begin
            if (s.param_count < MAX_P) n.param_count = s.param_count + 4'd1;
            else                       n.overflow    = 1'b1;
        end
        return n;
    endfunction

    // Result word for one tagged byte; counts come from the updated state
    function automatic irclt_pkg::out_item_t tag_out(
        input irclt_pkg::parse_state_t s, input irclt_pkg::parse_state_t n,
        input logic [7:0] b);
        irclt_pkg::out_item_t o;
        o = '0;
        o.data_byte      = b;
        o.param_number   = n.param_count;
        o.param_overflow = n.overflow;
        unique case (s.phase)
            irclt_pkg::PH_PREFIX: begin
                if (b != irclt_pkg::CH_SPACE) begin
                    o.field_kind  = irclt_pkg::KIND_PREFIX;
                    o.field_start = s.start_due;
                end
            end
            irclt_pkg::PH_PRE_CMD: begin
                if (b != irclt_pkg::CH_SPACE) begin
                    o.field_kind  = irclt_pkg::KIND_CMD;
                    o.field_start = 1'b1;
                end
            end
            irclt_pkg::PH_CMD: begin
                if (b != irclt_pkg::CH_SPACE) o.field_kind = irclt_pkg::KIND_CMD;
            end
            irclt_pkg::PH_PRE_PARAM: begin
                if (b != irclt_pkg::CH_SPACE && b != irclt_pkg::CH_COLON) begin
                    o.field_kind  = irclt_pkg::KIND_MIDDLE;
                    o.field_start = 1'b1;
                end
            end
            irclt_pkg::PH_MIDDLE: begin
                if (b != irclt_pkg::CH_SPACE) o.field_kind = irclt_pkg::KIND_MIDDLE;
            end
            irclt_pkg::PH_TRAILING: begin
                o.field_kind  = irclt_pkg::KIND_TRAIL;
                o.field_start = s.start_due;
            end
            default: begin
                if (b != irclt_pkg::CH_SPACE && b != irclt_pkg::CH_COLON) begin
                    o.field_kind  = irclt_pkg::KIND_CMD;
                    o.field_start = 1'b1;
                end
            end
        endcase
        return o;
    endfunction

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (cnt_reg <= QCW'(QDEPTH - 2));
    assign m_tvalid = (cnt_reg != '0);

    // Per-byte parse: optional released CR, then the new byte
    always_comb begin
        st_mid       = st_reg;
        st_next      = st_reg;
        cr_held_next = cr_held_reg;
        item0        = '0;
        item1        = '0;
        push0        = 1'b0;
        push1        = 1'b0;
        if (in_fire) begin
            if (cr_held_reg && s_tdata == irclt_pkg::CH_LF) begin
                // End of line word
                item0.data_byte      = irclt_pkg::CH_LF;
                item0.field_kind     = irclt_pkg::KIND_SEP;
                item0.param_number   = st_reg.param_count;
                item0.param_overflow = st_reg.overflow;
                item0.line_end       = 1'b1;
                item0.line_valid     = (st_reg.phase == irclt_pkg::PH_CMD)
                                    || (st_reg.phase == irclt_pkg::PH_PRE_PARAM)
                                    || (st_reg.phase == irclt_pkg::PH_MIDDLE)
                                    || (st_reg.phase == irclt_pkg::PH_TRAILING);
                item0.last_of_run    = 1'b1;
                push0                = 1'b1;
                cr_held_next         = 1'b0;
                st_next              = '{phase: irclt_pkg::PH_LINE_START,
                                         param_count: 4'd0,
                                         overflow: 1'b0, start_due: 1'b0};
            end else begin
                if (cr_held_reg) begin
                    st_mid = next_state(st_reg, irclt_pkg::CH_CR);
                    item0  = tag_out(st_reg, st_mid, irclt_pkg::CH_CR);
                    push0  = 1'b1;
                end
                if (s_tdata == irclt_pkg::CH_CR) begin
                    cr_held_next      = 1'b1;
                    st_next           = st_mid;
                    item0.last_of_run = 1'b1;
                end else begin
                    cr_held_next      = 1'b0;
                    st_next           = next_state(st_mid, s_tdata);
                    item1             = tag_out(st_mid, st_next, s_tdata);
                    item1.last_of_run = 1'b1;
                    push1             = 1'b1;
                end
            end
        end
    end

    assign n_push   = QCW'(push0) + QCW'(push1);
    assign cnt_next = cnt_reg + n_push - QCW'(out_fire);

    // Parser and queue control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= '{phase: irclt_pkg::PH_LINE_START, param_count: 4'd0,
                             overflow: 1'b0, start_due: 1'b0};
            cr_held_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
        end else begin
            st_reg      <= st_next;
            cr_held_reg <= cr_held_next;
            wr_ptr_reg  <= wr_ptr_reg + QAW'(n_push);
            rd_ptr_reg  <= rd_ptr_reg + QAW'(out_fire);
            cnt_reg     <= cnt_next;
        end
    end

    // Result queue entries: packed in order, item0 first
    always_ff @(posedge aclk) begin
        if (push0) begin
            q_reg[wr_ptr_reg] <= item0;
        end
        if (push1) begin
            q_reg[push0 ? wr_ptr_reg + QAW'(1) : wr_ptr_reg] <= item1;
        end
    end

    // Head of queue drives the master port
    always_comb begin
        irclt_pkg::out_item_t h;
        h       = q_reg[rd_ptr_reg];
        m_tdata = {h.line_valid, h.line_end, h.param_overflow, h.field_start,
                   h.param_number, h.data_byte};
        m_tuser = h.field_kind;
        m_tlast = h.last_of_run;
    end

    // Queue never holds more than its depth
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCW'(QDEPTH))
        else $error("result queue overfilled");

    // End-of-line word is a separator and closes its run
    a_eol_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[14]) |-> (m_tuser == irclt_pkg::KIND_SEP && m_tlast))
        else $error("malformed end-of-line word");

    // line_valid only appears on the end-of-line word
    a_valid_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[15]) |-> m_tdata[14])
        else $error("line_valid without line_end");

    // An accepted CR is always held for the next byte
    a_cr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tdata == irclt_pkg::CH_CR) |=> cr_held_reg)
        else $error("carriage return not held");

endmodule

[dv/tb_irc_line_tokenizer.sv]
// Self-checking testbench for irc_line_tokenizer: directed and random IRC lines,
// predicted per byte and compared word by word on the result stream.
// Depends on irclt_pkg and irc_line_tokenizer.
`timescale 1ns / 1ps

module tb_irc_line_tokenizer;

    localparam int MAX_PARAMS  = 15;
    localparam int CYCLE_LIMIT = 500000;

    // DUT interface
    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Traffic shaping, in percent per cycle
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    int mismatches  = 0;
    int bytes_sent  = 0;
    int cycle_count = 0;

    // Expected result words, oldest first
    irclt_pkg::out_item_t expected_tokens[$];

    // Parser state mirror
    irclt_pkg::phase_t line_phase    = irclt_pkg::PH_LINE_START;
    logic              cr_waiting    = 1'b0;
    logic [3:0]        param_cnt     = 4'd0;
    logic              param_ovf     = 1'b0;
    logic              start_pending = 1'b0;

    irc_line_tokenizer #(
        .MAX_PARAMS(MAX_PARAMS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("irc_line_tokenizer: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Append one word to the expected list
    function automatic void queue_word(input irclt_pkg::out_item_t w);
        expected_tokens.insert(expected_tokens.size(), w);
    endfunction

    // New parameter: count saturates, overflow goes sticky
    function automatic void open_param();
        if (param_cnt < MAX_PARAMS)
            param_cnt = param_cnt + 4'd1;
        else
            param_ovf = 1'b1;
    endfunction

    // Tag one character and advance the phase
    function automatic irclt_pkg::out_item_t tag_char(input logic [7:0] c);
        irclt_pkg::out_item_t t;
        logic [2:0]           kind;
        logic                 first;
        kind  = irclt_pkg::KIND_SEP;
        first = 1'b0;
        case (line_phase)
            irclt_pkg::PH_PREFIX: begin
                if (c == irclt_pkg::CH_SPACE) begin
                    line_phase = irclt_pkg::PH_PRE_CMD;
                end else begin
                    kind          = irclt_pkg::KIND_PREFIX;
                    first         = start_pending;
                    start_pending = 1'b0;
                end
            end
            irclt_pkg::PH_PRE_CMD: begin
                if (c != irclt_pkg::CH_SPACE) begin
                    line_phase = irclt_pkg::PH_CMD;
                    kind       = irclt_pkg::KIND_CMD;
                    first      = 1'b1;
                end
            end
            irclt_pkg::PH_CMD: begin
                if (c == irclt_pkg::CH_SPACE)
                    line_phase = irclt_pkg::PH_PRE_PARAM;
                else
                    kind = irclt_pkg::KIND_CMD;
            end
            irclt_pkg::PH_PRE_PARAM: begin
                if (c == irclt_pkg::CH_COLON) begin
                    open_param();
                    line_phase    = irclt_pkg::PH_TRAILING;
                    start_pending = 1'b1;
                end else if (c != irclt_pkg::CH_SPACE) begin
                    open_param();
                    line_phase = irclt_pkg::PH_MIDDLE;
                    kind       = irclt_pkg::KIND_MIDDLE;
                    first      = 1'b1;
                end
            end
            irclt_pkg::PH_MIDDLE: begin
                if (c == irclt_pkg::CH_SPACE)
                    line_phase = irclt_pkg::PH_PRE_PARAM;
                else
                    kind = irclt_pkg::KIND_MIDDLE;
            end
            irclt_pkg::PH_TRAILING: begin
                kind          = irclt_pkg::KIND_TRAIL;
                first         = start_pending;
                start_pending = 1'b0;
            end
            default: begin
                // line start: colon opens a prefix, otherwise the command begins
                if (c == irclt_pkg::CH_COLON) begin
                    line_phase    = irclt_pkg::PH_PREFIX;
                    start_pending = 1'b1;
                end else if (c == irclt_pkg::CH_SPACE) begin
                    line_phase = irclt_pkg::PH_PRE_CMD;
                end else begin
                    line_phase = irclt_pkg::PH_CMD;
                    kind       = irclt_pkg::KIND_CMD;
                    first      = 1'b1;
                end
            end
        endcase
        t                = '0;
        t.data_byte      = c;
        t.field_kind     = kind;
        t.param_number   = param_cnt;
        t.field_start    = first;
        t.param_overflow = param_ovf;
        return t;
    endfunction

    // Expected words for one accepted input byte
    function automatic void tokenize_byte(input logic [7:0] b);
        irclt_pkg::out_item_t cr_word;
        irclt_pkg::out_item_t cur_word;
        logic                 cr_released;
        logic                 have_cur;
        cr_released = 1'b0;
        have_cur    = 1'b0;
        if (cr_waiting) begin
            cr_waiting = 1'b0;
            if (b == irclt_pkg::CH_LF) begin
                // CRLF: end-of-line word, parser back to line start
                cur_word                = '0;
                cur_word.data_byte      = irclt_pkg::CH_LF;
                cur_word.field_kind     = irclt_pkg::KIND_SEP;
                cur_word.param_number   = param_cnt;
                cur_word.param_overflow = param_ovf;
                cur_word.line_end       = 1'b1;
                cur_word.line_valid     = (line_phase == irclt_pkg::PH_CMD) ||
                                          (line_phase == irclt_pkg::PH_PRE_PARAM) ||
                                          (line_phase == irclt_pkg::PH_MIDDLE) ||
                                          (line_phase == irclt_pkg::PH_TRAILING);
                cur_word.last_of_run    = 1'b1;
                queue_word(cur_word);
                line_phase    = irclt_pkg::PH_LINE_START;
                param_cnt     = 4'd0;
                param_ovf     = 1'b0;
                start_pending = 1'b0;
                return;
            end
            // held CR goes out as plain data
            cr_word     = tag_char(irclt_pkg::CH_CR);
            cr_released = 1'b1;
        end
        if (b == irclt_pkg::CH_CR) begin
            cr_waiting = 1'b1;
        end else begin
            cur_word             = tag_char(b);
            cur_word.last_of_run = 1'b1;
            have_cur             = 1'b1;
        end
        if (cr_released) begin
            cr_word.last_of_run = !have_cur;
            queue_word(cr_word);
        end
        if (have_cur)
            queue_word(cur_word);
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Send one byte, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        tokenize_byte(b);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_crlf();
        send_byte(irclt_pkg::CH_CR);
        send_byte(irclt_pkg::CH_LF);
    endtask

    // Hold off the input until every expected word is out
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_tokens.size() != 0);
    endtask

    // Token character: never space or CR, colon optional
    function automatic logic [7:0] token_char(input logic allow_colon);
        logic [7:0] c;
        do c = 8'($urandom_range(255));
        while (c == irclt_pkg::CH_SPACE || c == irclt_pkg::CH_CR ||
               (!allow_colon && c == irclt_pkg::CH_COLON));
        return c;
    endfunction

    // Trailing text: spaces and colons are frequent
    function automatic logic [7:0] trail_char();
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return irclt_pkg::CH_SPACE;
        if (r == 1)
            return irclt_pkg::CH_COLON;
        return token_char(1'b1);
    endfunction

    // Byte biased toward the characters the parser cares about
    function automatic logic [7:0] noise_char();
        case ($urandom_range(9))
            0:       return irclt_pkg::CH_CR;
            1:       return irclt_pkg::CH_LF;
            2:       return irclt_pkg::CH_COLON;
            3:       return irclt_pkg::CH_SPACE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Well-formed line with random content
    task automatic send_wellformed_line();
        int n_par;
        int len;
        if ($urandom_range(1)) begin
            send_byte(irclt_pkg::CH_COLON);
            len = $urandom_range(1, 6);
            repeat (len) send_byte(token_char(1'b1));
            send_byte(irclt_pkg::CH_SPACE);
        end else if ($urandom_range(7) == 0) begin
            send_byte(irclt_pkg::CH_SPACE);
        end
        // command
        send_byte(token_char(1'b0));
        len = $urandom_range(0, 4);
        repeat (len) send_byte(token_char(1'b1));
        // parameters; now and then past the limit
        n_par = ($urandom_range(9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4);
        for (int i = 0; i < n_par; i++) begin
            send_byte(irclt_pkg::CH_SPACE);
            if ($urandom_range(7) == 0)
                send_byte(irclt_pkg::CH_SPACE);
            if (i == n_par - 1 && $urandom_range(1)) begin
                send_byte(irclt_pkg::CH_COLON);
                len = $urandom_range(0, 8);
                repeat (len) send_byte(trail_char());
            end else begin
                send_byte(token_char(1'b0));
                len = $urandom_range(0, 4);
                repeat (len) send_byte(token_char(1'b1));
            end
        end
        send_crlf();
    endtask

    // Broken or arbitrary byte runs
    task automatic send_noise();
        int len;
        len = $urandom_range(1, 10);
        repeat (len) send_byte(noise_char());
        if ($urandom_range(1))
            send_crlf();
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Result sink: random stalls, compare each accepted word
    always @(posedge aclk) begin : result_sink
        irclt_pkg::out_item_t want;
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected result word: tdata 0x%0h tuser 0x%0h",
                       m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = expected_tokens[0];
                expected_tokens.delete(0);
                check_field("data_byte", want.data_byte, m_tdata[7:0]);
                check_field("field_kind", want.field_kind, m_tuser);
                check_field("param_number", want.param_number, m_tdata[11:8]);
                check_field("field_start", want.field_start, m_tdata[12]);
                check_field("param_overflow", want.param_overflow, m_tdata[13]);
                check_field("line_end", want.line_end, m_tdata[14]);
                check_field("line_valid", want.line_valid, m_tdata[15]);
                check_field("last_of_run", want.last_of_run, m_tlast);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every field kind, byte extremes and the CR corner cases
    task automatic test_directed_lines();
        // prefix, command, middle and trailing with an inner space
        send_text(":p C m :t u");
        send_crlf();
        // leading space, 0x00 command, bare LF, released CR, CR CR LF
        send_byte(irclt_pkg::CH_SPACE);
        send_byte(8'h00);
        send_byte(irclt_pkg::CH_LF);
        send_byte(irclt_pkg::CH_CR);
        send_byte("Y");
        send_byte(irclt_pkg::CH_CR);
        send_crlf();
        // prefix only: line not valid
        send_byte(irclt_pkg::CH_COLON);
        send_byte(8'hFF);
        send_crlf();
        // empty line
        send_crlf();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_bytes);
        int stop_at;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        stop_at        = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(99) < 85)
                send_wellformed_line();
            else
                send_noise();
        end
    endtask

    task automatic finish_run();
        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("irc_line_tokenizer: match");
        else
            $display("irc_line_tokenizer: mismatch");
        $finish;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_lines();
        test_random_traffic(0, 0, 320);
        test_random_traffic(84, 0, 310);
        wait_results_drained();
        test_random_traffic(0, 84, 310);
        test_random_traffic(18, 18, 310);
        finish_run();
    end

endmodule

[filelist.f]
sv/irclt_pkg.sv
sv/irc_line_tokenizer.sv
dv/tb_irc_line_tokenizer.sv
